/* design/clp_pkg.sv */
// Shared types, constants and helpers for the chunk size line parser.
// Used by clp_front, clp_queue, clp_back and chunk_size_line_parser_core.
package clp_pkg;

    // Byte codes that end a size line
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Field and state widths
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 8;
    localparam int CNT_W          = 9;
    localparam int STATUS_W       = 2;
    localparam int CHUNK_W        = 32;
    localparam int DIGIT_W        = 4;
    localparam int SIZE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic                 cmd;      // restart when set
        logic                 is_hex;
        logic [DIGIT_W-1:0]   digit;
        logic                 is_cr;
        logic                 is_lf;
    } clp_item_t;

    // Hex digit value, valid only when hex_valid is true
    function automatic logic [DIGIT_W-1:0] hex_digit(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        begin
            v = 8'h00;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                v = b - 8'h30;
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                v = b - 8'h57;
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                v = b - 8'h37;
            end
            return v[DIGIT_W-1:0];
        end
    endfunction

    function automatic logic hex_valid(input logic [BYTE_W-1:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

endpackage

/* design/chunk_size_line_parser_core.sv */
// Path: an accepted byte is stored in the queue, then parsed into the output register that drives m_tvalid.
// Throughput: one byte per cycle while m_tready is high; the parser state machine updates
// once per popped item and a two-entry queue plus an output register keep both sides moving.
// Reset: rst_n is asynchronous, active low; it empties the queue and output,
// returns the parser to awaiting the first digit, and sets max_line_len to 32.
module chunk_size_line_parser_core
#(
    parameter int SIZE_WIDTH = clp_pkg::SIZE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] cmd
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] status, [33:2] chunk_size, [39:34] zero
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import clp_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 8'd32;

    logic [LEN_W-1:0]   max_len_reg;
    logic               cfg_wr;
    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    clp_item_t          push_item;
    clp_item_t          head_item;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'h0 : {{(32-LEN_W){1'b0}}, max_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            max_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    clp_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    clp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    clp_back #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_line_len (max_len_reg),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

/* design/clp_front.sv */
// Front end: accepts input transactions and classifies each byte.
// Depends on clp_pkg; feeds clp_queue.
module clp_front
(
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] byte_in
    input  logic                        s_tuser,   // [0] cmd
    input  logic                        q_full,
    output logic                        q_push,
    output clp_pkg::clp_item_t          q_item
);
    import clp_pkg::*;

    logic [BYTE_W-1:0] byte_val;

    assign byte_val = s_tdata;

    // Take a transaction whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classify the byte
    always_comb
    begin
        q_item.cmd    = s_tuser;
        q_item.is_hex = hex_valid(byte_val);
        q_item.digit  = hex_digit(byte_val);
        q_item.is_cr  = (byte_val == CH_CR);
        q_item.is_lf  = (byte_val == CH_LF);
    end

endmodule

/* design/clp_queue.sv */
// Short queue that decouples the classifying front from the parsing back.
// Depends on clp_pkg for the item type and depth.
module clp_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  clp_pkg::clp_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output clp_pkg::clp_item_t  head_item
);
    import clp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    clp_item_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    assign full       = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Check queue bookkeeping
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid) else $error("pop from empty queue");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH)) else $error("queue fill out of range");

endmodule

/* design/clp_back.sv */
// Back end: runs the size line state machine on queued items and holds the result.
// Depends on clp_pkg; pops from clp_queue and drives the master stream.
module clp_back
#(
    parameter int SIZE_WIDTH = clp_pkg::SIZE_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [clp_pkg::LEN_W-1:0]   max_line_len,
    input  logic                        q_valid,
    input  clp_pkg::clp_item_t          q_item,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata   // [1:0] status, [33:2] chunk_size, [39:34] zero
);
    import clp_pkg::*;

    // Parser states
    localparam logic [2:0] ST_FIRST  = 3'd0;
    localparam logic [2:0] ST_DIGITS = 3'd1;
    localparam logic [2:0] ST_LF1    = 3'd2;
    localparam logic [2:0] ST_CR2    = 3'd3;
    localparam logic [2:0] ST_LF2    = 3'd4;

    // Result codes
    localparam logic [STATUS_W-1:0] RES_MORE = 2'd0;
    localparam logic [STATUS_W-1:0] RES_OK   = 2'd1;
    localparam logic [STATUS_W-1:0] RES_ERR  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next, cnt_inc;
    logic [SIZE_WIDTH-1:0]  size_reg, size_next;
    logic [STATUS_W-1:0]    status_c;
    logic [CHUNK_W-1:0]     chunk_view;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [CHUNK_W-1:0]     chunk_reg;
    logic                   size_top_set;

    // Pop when the output register is free or being drained
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    assign cnt_inc      = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign size_top_set = (size_reg[SIZE_WIDTH-1 -: DIGIT_W] != '0);

    // Parse one item
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        size_next  = size_reg;
        status_c   = RES_MORE;
        if (q_item.cmd)
        begin
            state_next = ST_FIRST;
            cnt_next   = '0;
            size_next  = '0;
        end
        else
        begin
            cnt_next = cnt_inc;
            if (cnt_inc > {1'b0, max_line_len})
            begin
                status_c = RES_ERR;
            end
            else
            begin
                unique case (state_reg)
                    ST_FIRST:
                    begin
                        if (q_item.is_hex)
                        begin
                            size_next  = {{(SIZE_WIDTH-DIGIT_W){1'b0}}, q_item.digit};
                            state_next = ST_DIGITS;
                        end
                        else if (!(q_item.is_cr || q_item.is_lf))
                        begin
                            status_c = RES_ERR;
                        end
                    end
                    ST_DIGITS:
                    begin
                        if (q_item.is_hex)
                        begin
                            if (size_top_set)
                            begin
                                status_c = RES_ERR;
                            end
                            else
                            begin
                                size_next = {size_reg[SIZE_WIDTH-DIGIT_W-1:0], q_item.digit};
                            end
                        end
                        else if (q_item.is_cr)
                        begin
                            state_next = ST_LF1;
                        end
                        else
                        begin
                            status_c = RES_ERR;
                        end
                    end
                    ST_LF1:
                    begin
                        if (!q_item.is_lf)
                        begin
                            status_c = RES_ERR;
                        end
                        else if (size_reg != '0)
                        begin
                            status_c = RES_OK;
                        end
                        else
                        begin
                            state_next = ST_CR2;
                        end
                    end
                    ST_CR2:
                    begin
                        if (q_item.is_cr)
                        begin
                            state_next = ST_LF2;
                        end
                        else
                        begin
                            status_c = RES_ERR;
                        end
                    end
                    ST_LF2:
                    begin
                        status_c = q_item.is_lf ? RES_OK : RES_ERR;
                    end
                    default:
                    begin
                        status_c = RES_ERR;
                    end
                endcase
            end
        end
    end

    // Show the low bits of the size
    generate
        if (SIZE_WIDTH >= CHUNK_W)
        begin : g_wide
            assign chunk_view = size_next[CHUNK_W-1:0];
        end
        else
        begin : g_narrow
            assign chunk_view = {{(CHUNK_W-SIZE_WIDTH){1'b0}}, size_next};
        end
    endgenerate

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FIRST;
            cnt_reg       <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                state_reg <= state_next;
                cnt_reg   <= cnt_next;
                size_reg  <= size_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_c;
            chunk_reg  <= chunk_view;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, chunk_reg, status_reg};

    // Restart clears the count and size
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.cmd) |=> (cnt_reg == '0 && size_reg == '0 && state_reg == ST_FIRST))
        else $error("restart did not clear parser");
    // Every popped item yields a result
    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg) else $error("popped item lost");
    // A waiting result is never overwritten
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> ($stable(status_reg) && $stable(chunk_reg)))
        else $error("pending result overwritten");
    // Line length error never changes the state or size
    a_len_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_item.cmd && (cnt_inc > {1'b0, max_line_len}))
        |=> ($stable(state_reg) && $stable(size_reg)))
        else $error("over-length byte changed state");

endmodule
